FILE: hw/rtl/indexed_list_store_top_defines.svh
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared property templates for the checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication
`define ILS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list store package
// Sizes, command and status codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 3;
    localparam int POS_W       = 7;
    localparam int ST_W        = 2;
    localparam int CMP_W       = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam int IN_POS_LSB  = CMD_W;
    localparam int IN_VAL_LSB  = CMD_W + POS_W;
    localparam int IN_W        = CMD_W + POS_W + VALUE_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

    localparam int OUT_ST_LSB  = VALUE_BITS;
    localparam int OUT_LEN_LSB = VALUE_BITS + ST_W;
    localparam int OUT_W       = VALUE_BITS + ST_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ      = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_APPEND    = 3'd2,
        CMD_INS_AT    = 3'd3,
        CMD_DELETE    = 3'd4
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CUR_HOLD = 2'd0,
        CUR_HEAD = 2'd1,
        CUR_STEP = 2'd2
    } cur_op_t;

    typedef enum logic [2:0] {
        LW_NONE     = 3'd0,
        LW_NEW_HEAD = 3'd1,
        LW_NEW_Q    = 3'd2,
        LW_CUR_NEW  = 3'd3,
        LW_PREV_Q   = 3'd4
    } link_wr_t;

    typedef enum logic [1:0] {
        HD_KEEP = 2'd0,
        HD_NEW  = 2'd1,
        HD_LINK = 2'd2
    } head_op_t;

    typedef enum logic [1:0] {
        LEN_KEEP = 2'd0,
        LEN_INC  = 2'd1,
        LEN_DEC  = 2'd2
    } len_op_t;

    typedef struct packed {
        logic     load_in;
        cur_op_t  cur_op;
        logic     cnt_load;
        logic     cnt_dec;
        logic     pop;
        logic     push;
        logic     save_prev;
        logic     val_wr;
        link_wr_t link_wr;
        head_op_t head_op;
        len_op_t  len_op;
        logic     st_set;
        status_t  st_val;
        logic     out_load;
    } ils_ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic pos_ok;
        logic pos_zero;
        logic ins_bad;
        logic ins_head;
        logic full;
        logic cnt_zero;
        logic out_busy;
    } ils_sts_t;

endpackage

FILE: hw/rtl/ils_datapath.sv
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Value, link and free-slot memories, list pointers and the result register.
// ----------------------------------------------------------------------------
module ils_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ils_pkg::ils_ctl_t              ctl,
    output ils_pkg::ils_sts_t              sts,
    input  logic [ils_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ils_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ils_pkg::*;

    logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
    logic [IDX_W-1:0]      link_mem [CAPACITY];
    logic [IDX_W-1:0]      pool_mem [CAPACITY];

    cmd_t                  cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      free_reg, free_next;
    logic [CNT_W-1:0]      low_reg, low_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      prev_reg;
    logic [IDX_W-1:0]      new_reg;
    logic [IDX_W-1:0]      cnt_reg;
    status_t               status_reg;
    logic [IDX_W-1:0]      link_q;
    logic [VALUE_BITS-1:0] val_q;
    logic [IDX_W-1:0]      pool_q;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic [ST_W-1:0]       out_st_reg;
    logic [CNT_W-1:0]      out_len_reg;

    logic [CMP_W-1:0]      pos_ext, len_ext, ins_pos;
    logic [IDX_W-1:0]      cnt_load_val;
    logic [CNT_W-1:0]      pool_idx;
    logic [IDX_W-1:0]      pool_addr, pop_slot;
    logic                  push_en;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr, link_wdata;
    logic [VALUE_BITS-1:0] rd_value;

    assign pos_ext   = CMP_W'(pos_reg);
    assign len_ext   = CMP_W'(len_reg);
    assign pool_idx  = free_reg - CNT_W'(1);
    assign pool_addr = pool_idx[IDX_W-1:0];
    // stack entries below the low-water mark were never pushed and still hold their index
    assign pop_slot  = (pool_idx >= low_reg) ? pool_q : pool_addr;
    assign push_en   = ctl.push && (free_reg < CNT_W'(CAPACITY));

    always_comb
    begin
        case (cmd_reg)
            CMD_INS_FRONT: ins_pos = '0;
            CMD_APPEND:    ins_pos = len_ext;
            default:       ins_pos = pos_ext;
        endcase
        case (cmd_reg)
            CMD_READ:   cnt_load_val = pos_reg[IDX_W-1:0];
            CMD_DELETE: cnt_load_val = IDX_W'(pos_ext - CMP_W'(1));
            default:    cnt_load_val = IDX_W'(ins_pos - CMP_W'(1));
        endcase
    end

    always_comb
    begin
        sts.cmd      = cmd_reg;
        sts.pos_ok   = pos_ext < len_ext;
        sts.pos_zero = pos_reg == '0;
        sts.ins_bad  = ins_pos > len_ext;
        sts.ins_head = ins_pos == '0;
        sts.full     = free_reg == '0;
        sts.cnt_zero = cnt_reg == '0;
        sts.out_busy = out_valid_reg && !m_tready;
    end

    always_comb
    begin
        case (ctl.cur_op)
            CUR_HEAD: cur_next = head_reg;
            CUR_STEP: cur_next = link_q;
            default:  cur_next = cur_reg;
        endcase

        link_we    = 1'b1;
        link_waddr = new_reg;
        link_wdata = link_q;
        case (ctl.link_wr)
            LW_NEW_HEAD: link_wdata = head_reg;
            LW_NEW_Q:    link_wdata = link_q;
            LW_CUR_NEW:
            begin
                link_waddr = cur_reg;
                link_wdata = new_reg;
            end
            LW_PREV_Q:   link_waddr = prev_reg;
            default:     link_we = 1'b0;
        endcase

        case (ctl.head_op)
            HD_NEW:  head_next = new_reg;
            HD_LINK: head_next = link_q;
            default: head_next = head_reg;
        endcase

        case (ctl.len_op)
            LEN_INC: len_next = len_reg + CNT_W'(1);
            LEN_DEC: len_next = len_reg - CNT_W'(1);
            default: len_next = len_reg;
        endcase

        free_next = free_reg;
        low_next  = low_reg;
        if (ctl.pop)
        begin
            free_next = pool_idx;
            if (pool_idx < low_reg)
                low_next = pool_idx;
        end
        else if (push_en)
        begin
            free_next = free_reg + CNT_W'(1);
        end

        if (cmd_reg != CMD_READ)
            rd_value = '0;
        else if (status_reg == ST_DONE)
            rd_value = val_q;
        else
            rd_value = '1;
    end

    // reads always track cur_next so link_q and val_q describe cur_reg
    always_ff @(posedge clk)
    begin
        if (ctl.val_wr)
            val_mem[new_reg] <= value_reg;
        val_q <= val_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        link_q <= link_mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            pool_mem[free_reg[IDX_W-1:0]] <= cur_reg;
        pool_q <= pool_mem[pool_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            len_reg       <= '0;
            free_reg      <= CNT_W'(CAPACITY);
            low_reg       <= CNT_W'(CAPACITY);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            len_reg  <= len_next;
            free_reg <= free_next;
            low_reg  <= low_next;
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg   <= cmd_t'(s_tdata[CMD_W-1:0]);
            pos_reg   <= s_tdata[IN_POS_LSB +: POS_W];
            value_reg <= s_tdata[IN_VAL_LSB +: VALUE_BITS];
        end
        cur_reg <= cur_next;
        if (ctl.save_prev)
            prev_reg <= cur_reg;
        if (ctl.pop)
            new_reg <= pop_slot;
        if (ctl.cnt_load)
            cnt_reg <= cnt_load_val;
        else if (ctl.cnt_dec)
            cnt_reg <= cnt_reg - IDX_W'(1);
        if (ctl.st_set)
            status_reg <= ctl.st_val;
        if (ctl.out_load)
        begin
            out_val_reg <= rd_value;
            out_st_reg  <= status_reg;
            out_len_reg <= len_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_len_reg, out_st_reg, out_val_reg});

endmodule

FILE: hw/rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences decode, list walk, link update and result hand-off.
// ----------------------------------------------------------------------------
module ils_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ils_pkg::ils_sts_t sts,
    output ils_pkg::ils_ctl_t ctl
);
    import ils_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECIDE   = 9'b000000010,
        S_WALK     = 9'b000000100,
        S_INS_HEAD = 9'b000001000,
        S_INS_A    = 9'b000010000,
        S_INS_B    = 9'b000100000,
        S_DEL_STEP = 9'b001000000,
        S_DEL_FIX  = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        ctl            = '0;
        ctl.cur_op     = CUR_HOLD;
        ctl.link_wr    = LW_NONE;
        ctl.head_op    = HD_KEEP;
        ctl.len_op     = LEN_KEEP;
        ctl.st_val     = ST_DONE;
        state_next     = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                ctl.cur_op = CUR_HEAD;
                if (s_tvalid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.st_set = 1'b1;
                state_next = S_RESP;
                case (sts.cmd)
                    CMD_READ:
                    begin
                        if (sts.pos_ok)
                        begin
                            ctl.cnt_load = 1'b1;
                            state_next   = S_WALK;
                        end
                        else
                            ctl.st_val = ST_RANGE;
                    end
                    CMD_INS_FRONT, CMD_APPEND, CMD_INS_AT:
                    begin
                        if (sts.ins_bad)
                            ctl.st_val = ST_RANGE;
                        else if (sts.full)
                            ctl.st_val = ST_FULL;
                        else
                        begin
                            ctl.pop = 1'b1;
                            if (sts.ins_head)
                                state_next = S_INS_HEAD;
                            else
                            begin
                                ctl.cnt_load = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (!sts.pos_ok)
                            ctl.st_val = ST_RANGE;
                        else if (sts.pos_zero)
                            state_next = S_DEL_FIX;
                        else
                        begin
                            ctl.cnt_load = 1'b1;
                            state_next   = S_WALK;
                        end
                    end
                    default:
                        ctl.st_val = ST_RANGE;
                endcase
            end
            S_WALK:
            begin
                if (!sts.cnt_zero)
                begin
                    ctl.cur_op  = CUR_STEP;
                    ctl.cnt_dec = 1'b1;
                end
                else if (sts.cmd == CMD_READ)
                    state_next = S_RESP;
                else if (sts.cmd == CMD_DELETE)
                    state_next = S_DEL_STEP;
                else
                    state_next = S_INS_A;
            end
            S_INS_HEAD:
            begin
                ctl.val_wr  = 1'b1;
                ctl.link_wr = LW_NEW_HEAD;
                ctl.head_op = HD_NEW;
                ctl.len_op  = LEN_INC;
                state_next  = S_RESP;
            end
            S_INS_A:
            begin
                ctl.val_wr  = 1'b1;
                ctl.link_wr = LW_NEW_Q;
                state_next  = S_INS_B;
            end
            S_INS_B:
            begin
                ctl.link_wr = LW_CUR_NEW;
                ctl.len_op  = LEN_INC;
                state_next  = S_RESP;
            end
            S_DEL_STEP:
            begin
                ctl.save_prev = 1'b1;
                ctl.cur_op    = CUR_STEP;
                state_next    = S_DEL_FIX;
            end
            S_DEL_FIX:
            begin
                if (sts.pos_zero)
                    ctl.head_op = HD_LINK;
                else
                    ctl.link_wr = LW_PREV_Q;
                ctl.push   = 1'b1;
                ctl.len_op = LEN_DEC;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// Indexed list store top level
// Bounded linked list of signed values with read, insert and delete commands.
// ----------------------------------------------------------------------------
// One request at a time: a command that reaches list position p walks the
// link memory one entry per cycle. Inserts at the front, deletes at position 0
// and refused or ignored commands need no walk. Every request returns exactly
// one result; the result register lets the next request start while it waits,
// and a stalled result only holds the following request in its final cycle.
module indexed_list_store_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[2:0], position[9:3], value[41:10], zero fill
    input  logic [ils_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0], status[33:32], length[40:34], zero fill
    output logic [ils_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ils_pkg::*;

    ils_ctl_t ctl;
    ils_sts_t sts;

    ils_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ils_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: hw/rtl/ils_checker.sv
// ----------------------------------------------------------------------------
// Indexed list store checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_store_top_defines.svh"

module ils_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ils_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ils_pkg::*;

    logic [ST_W-1:0]  out_st;
    logic [CNT_W-1:0] out_len;

    assign out_st  = m_tdata[OUT_ST_LSB +: ST_W];
    assign out_len = m_tdata[OUT_LEN_LSB +: CNT_W];

    `ILS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "busy after accept")
    `ILS_ASSERT_IMP(a_len_bound, clk, rst_n, m_tvalid, out_len <= CNT_W'(CAPACITY), "length over capacity")
    `ILS_ASSERT_IMP(a_full_len, clk, rst_n, m_tvalid && (out_st == ST_FULL), out_len == CNT_W'(CAPACITY), "full refusal below capacity")
    `ILS_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind indexed_list_store_top ils_checker u_ils_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/indexed_list_store_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Drives read, insert and delete requests over the slave stream with random
// gaps and checks every result against a queue-based model of the ordered
// list. Covers empty and full stores, out-of-range positions, unknown
// commands and a long output stall that backs the block up.
// ----------------------------------------------------------------------------
module indexed_list_store_top_tb;

    import ils_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD_A   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C   = 3'd7;
    localparam int               LIMIT_CYCLES = 400000;
    localparam int               DRAIN_CYCLES = 100;

    typedef struct {
        logic [VALUE_BITS-1:0] rd_value;
        status_t               st;
        logic [CNT_W-1:0]      len;
    } list_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [VALUE_BITS-1:0]  list_model[$];
    list_result_t           result_q[$];
    int                     err_cnt   = 0;
    int                     cycle_cnt = 0;
    int                     hold_req  = 0;
    bit                     tx_quiet  = 0;
    bit                     rx_quiet  = 0;

    indexed_list_store_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // list behavior applied at acceptance
    task automatic predict_result(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                  input logic [VALUE_BITS-1:0] val,
                                  output list_result_t res);
        int len;
        len          = list_model.size();
        res.rd_value = '0;
        res.st       = ST_DONE;
        case (cmd)
            CMD_READ:
            begin
                if (pos < len)
                    res.rd_value = list_model[pos];
                else
                begin
                    res.rd_value = '1;
                    res.st       = ST_RANGE;
                end
            end
            CMD_INS_FRONT, CMD_APPEND, CMD_INS_AT:
            begin
                if (cmd == CMD_INS_FRONT)
                    pos = '0;
                else if (cmd == CMD_APPEND)
                    pos = POS_W'(len);
                if (pos > len)
                    res.st = ST_RANGE;
                else if (len >= CAPACITY)
                    res.st = ST_FULL;
                else
                    list_model.insert(pos, val);
            end
            CMD_DELETE:
            begin
                if (pos >= len)
                    res.st = ST_RANGE;
                else
                    list_model.delete(pos);
            end
            default:
                res.st = ST_RANGE;
        endcase
        res.len = CNT_W'(list_model.size());
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VALUE_BITS-1:0] val);
        int                    gap;
        logic [IN_TDATA_W-1:0] word;
        list_result_t          res;
        gap  = tx_quiet ? 0 : $urandom_range(0, 5);
        word = '0;
        word[CMD_W-1:0]                = cmd;
        word[IN_POS_LSB +: POS_W]      = pos;
        word[IN_VAL_LSB +: VALUE_BITS] = val;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        predict_result(cmd, pos, val, res);
        result_q.push_back(res);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(VALUE_BITS-1){1'b1}}};
            1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, 127));
        return POS_W'($urandom_range(0, list_model.size()));
    endfunction

    // result checker
    always @(posedge clk)
    begin
        list_result_t          want;
        logic [VALUE_BITS-1:0] got_rd;
        status_t               got_st;
        logic [CNT_W-1:0]      got_len;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_rd  = m_tdata[VALUE_BITS-1:0];
            got_st  = status_t'(m_tdata[OUT_ST_LSB +: ST_W]);
            got_len = m_tdata[OUT_LEN_LSB +: CNT_W];
            if (result_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, actual value %h status %0d len %0d",
                         $time, got_rd, got_st, got_len);
            end
            else
            begin
                want = result_q.pop_front();
                if (got_rd !== want.rd_value || got_st !== want.st || got_len !== want.len)
                begin
                    err_cnt++;
                    $display("%0t: expected value %h status %0d len %0d, actual value %h status %0d len %0d",
                             $time, want.rd_value, want.st, want.len, got_rd, got_st, got_len);
                end
            end
        end
    end

    // result sink with random stalls; hold_req forces one long stall
    initial
    begin : rx_proc
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                gap      = hold_req;
                hold_req = 0;
            end
            else
                gap = rx_quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic test_directed();
        send_cmd(CMD_READ,      7'd0,   32'h1234_5678);
        send_cmd(CMD_DELETE,    7'd0,   32'h0);
        send_cmd(CMD_INS_AT,    7'd1,   32'h5555_aaaa);
        send_cmd(CMD_INS_AT,    7'd0,   32'h0000_0011);
        send_cmd(CMD_APPEND,    7'd0,   32'h7fff_ffff);
        send_cmd(CMD_INS_FRONT, 7'd127, 32'h8000_0000);
        send_cmd(CMD_READ,      7'd0,   32'h0);
        send_cmd(CMD_READ,      7'd1,   32'h0);
        send_cmd(CMD_READ,      7'd2,   32'h0);
        send_cmd(CMD_READ,      7'd3,   32'h0);
        send_cmd(CMD_INS_AT,    7'd3,   32'hffff_ffff);
        send_cmd(CMD_INS_AT,    7'd1,   32'h0);
        send_cmd(CMD_INS_AT,    7'd127, 32'haaaa_5555);
        send_cmd(CMD_READ,      7'd64,  32'h0);
        send_cmd(CMD_DELETE,    7'd0,   32'h0);
        send_cmd(CMD_READ,      7'd0,   32'h0);
        send_cmd(CMD_DELETE,    7'd3,   32'h0);
        send_cmd(CMD_DELETE,    7'd127, 32'h0);
        send_cmd(CMD_RSVD_A,    7'd0,   32'hdead_beef);
        send_cmd(CMD_RSVD_B,    7'd1,   32'h0);
        send_cmd(CMD_RSVD_C,    7'd127, 32'hffff_ffff);
        send_cmd(CMD_READ,      7'd2,   32'h0);
    endtask

    task automatic test_full_store();
        logic [CMD_W-1:0] cmd;
        while (list_model.size() < CAPACITY)
        begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_INS_FRONT;
                1: cmd = CMD_APPEND;
                default: cmd = CMD_INS_AT;
            endcase
            send_cmd(cmd, POS_W'($urandom_range(0, list_model.size())), pick_value());
        end
        send_cmd(CMD_INS_FRONT, 7'd0,  pick_value());
        send_cmd(CMD_APPEND,    7'd0,  pick_value());
        send_cmd(CMD_INS_AT,    7'd64, pick_value());
        send_cmd(CMD_INS_AT,    7'd65, pick_value());
        send_cmd(CMD_INS_AT,    7'd10, pick_value());
        send_cmd(CMD_READ,      7'd63, 32'h0);
        send_cmd(CMD_READ,      7'd64, 32'h0);
        send_cmd(CMD_DELETE,    7'd64, 32'h0);
        send_cmd(CMD_DELETE,    7'd63, 32'h0);
        send_cmd(CMD_DELETE,    7'd0,  32'h0);
        send_cmd(CMD_INS_AT,    7'd62, pick_value());
        send_cmd(CMD_READ,      7'd62, 32'h0);
    endtask

    task automatic test_random(input int n_items);
        int               r;
        bit               grow;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < n_items; i++)
        begin
            grow = ((i / 120) % 2) == 0;
            r    = $urandom_range(0, 99);
            if (r < 3)
                cmd = CMD_W'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
            else if (r < 28)
                cmd = CMD_READ;
            else if (r < (grow ? 83 : 48))
            begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_INS_FRONT;
                    1: cmd = CMD_APPEND;
                    default: cmd = CMD_INS_AT;
                endcase
            end
            else
                cmd = CMD_DELETE;
            send_cmd(cmd, pick_pos(), pick_value());
        end
    endtask

    task automatic test_backpressure();
        hold_req = 250;
        tx_quiet = 1'b1;
        for (int i = 0; i < 12; i++)
            send_cmd(CMD_INS_AT, pick_pos(), pick_value());
        tx_quiet = 1'b0;
    endtask

    task automatic test_no_idle();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        test_random(80);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_store();
        test_random(500);
        test_backpressure();
        test_no_idle();
        test_random(450);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
